/* hdl/trfm_pkg.sv */
package trfm_pkg;

  typedef enum logic [1:0] {
    CMD_COND  = 2'd0,
    CMD_HDR   = 2'd1,
    CMD_TAG   = 2'd2,
    CMD_EVAL  = 2'd3
  } cmd_t;

  localparam logic [1:0] OP_EXISTS = 2'd0;
  localparam logic [1:0] OP_EQ     = 2'd1;
  localparam logic [1:0] OP_NE     = 2'd2;
  localparam logic [1:0] KIND_REL  = 2'd3;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  fidx;
    logic [2:0]  cidx;
    logic [1:0]  kind;
    logic [4:0]  zl;
    logic [4:0]  zh;
    logic [3:0]  cnt;
    logic [4:0]  level;
    logic [31:0] key;
    logic [31:0] value;
    logic [1:0]  op;
    logic        last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_COND,
    ST_SRCH,
    ST_CHK,
    ST_OUT
  } state_t;

endpackage

/* hdl/trfm_queue.sv */
module trfm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  trfm_pkg::item_t    in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output trfm_pkg::item_t    out_item
);
  import trfm_pkg::*;

  item_t      mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;

  assign in_ready  = (cnt != 3'd4);
  assign out_valid = (cnt != 3'd0);
  assign out_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (in_valid && in_ready) wp <= wp + 2'd1;
      if (out_valid && out_ready) rp <= rp + 2'd1;
      cnt <= cnt + 3'((in_valid && in_ready) ? 1 : 0) - 3'((out_valid && out_ready) ? 1 : 0);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 3'd0) |-> !(out_valid))
    else $error("queue shows item while empty");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready)) |=> cnt == $past(cnt) + 3'd1)
    else $error("queue count lost a push");
endmodule

/* hdl/trfm_engine.sv */
module trfm_engine #(
  parameter int NUM_FILTERS    = 64,
  parameter int MAX_CONDITIONS = 8,
  parameter int MAX_TAGS       = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  trfm_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            applicable,
  output logic            tag_overflow
);
  import trfm_pkg::*;

  localparam int FW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int TW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int NW = $clog2(MAX_TAGS + 1);
  localparam int CNW = $clog2(MAX_CONDITIONS + 1);
  localparam int FCW = $clog2(NUM_FILTERS + 1);
  localparam int AW = (NUM_FILTERS * MAX_CONDITIONS > 1) ?
                      $clog2(NUM_FILTERS * MAX_CONDITIONS) : 1;

  logic [NUM_FILTERS-1:0] fvalid;
  logic [15:0]            hdr_mem  [NUM_FILTERS];
  logic [31:0]            ckey_mem [NUM_FILTERS*MAX_CONDITIONS];
  logic [33:0]            cvo_mem  [NUM_FILTERS*MAX_CONDITIONS];
  logic [31:0]            tkey_mem [MAX_TAGS];
  logic [31:0]            tval_mem [MAX_TAGS];

  logic [NW-1:0]  tag_count;
  logic           overflow_flag;
  state_t         state, state_next;
  item_t          cur;
  logic [FW-1:0]  f;
  logic [CNW-1:0] c;
  logic [CNW-1:0] fcnt;
  logic [NW-1:0]  lo, hi;
  logic           res_app, res_ovf;
  logic [NW-1:0]  nstored;

  // registered reads
  logic [15:0] hdr_q;
  logic [31:0] ckey_q;
  logic [33:0] cvo_q;
  logic [31:0] tkey_q, tval_q;

  logic [FCW-1:0] f_ext;
  logic [NW-1:0]  mid;
  logic           ovf_now;
  logic           is_cond_ok, is_hdr_ok;
  logic [AW-1:0]  cwr_idx, crd_idx;
  logic [FW-1:0]  fwr_idx;

  assign f_ext = FCW'(f);
  assign mid   = lo + ((hi - lo) >> 1);
  assign is_cond_ok = (32'(in_item.fidx) < 32'(NUM_FILTERS)) &&
                      (32'(in_item.cidx) < 32'(MAX_CONDITIONS));
  assign is_hdr_ok  = (32'(in_item.fidx) < 32'(NUM_FILTERS));
  assign ovf_now    = overflow_flag || (32'(tag_count) >= 32'(MAX_TAGS));
  assign fwr_idx    = FW'(in_item.fidx);
  assign cwr_idx    = AW'(32'(in_item.fidx) * 32'(MAX_CONDITIONS) + 32'(in_item.cidx));
  assign crd_idx    = AW'(32'(f) * 32'(MAX_CONDITIONS) + 32'(c));

  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = (state == ST_OUT);
  assign applicable = res_app;
  assign tag_overflow = res_ovf;

  // header of the filter being looked at, and its clamped count
  logic [1:0]  h_kind;
  logic [4:0]  h_zl, h_zh;
  logic [3:0]  h_cnt;
  logic        h_apply;
  assign h_kind = hdr_q[1:0];
  assign h_zl   = hdr_q[6:2];
  assign h_zh   = hdr_q[11:7];
  assign h_cnt  = hdr_q[15:12];
  assign h_apply = fvalid[f] && (h_kind == cur.kind) &&
                   (cur.level >= h_zl) && (cur.level <= h_zh);

  logic [CNW-1:0] cnt_cl;
  assign cnt_cl = (32'(h_cnt) > 32'(MAX_CONDITIONS)) ? CNW'(MAX_CONDITIONS)
                                                     : CNW'(h_cnt);

  // condition check against the tag read at mid
  logic        key_hit, key_gt, cond_ok;
  assign key_hit = (tkey_q == ckey_q);
  assign key_gt  = (tkey_q > ckey_q);
  always_comb begin
    case (cvo_q[33:32])
      OP_EXISTS: cond_ok = 1'b1;
      OP_EQ:     cond_ok = (tval_q == cvo_q[31:0]);
      OP_NE:     cond_ok = (tval_q != cvo_q[31:0]);
      default:   cond_ok = 1'b0;
    endcase
  end

  logic last_filter;
  assign last_filter = (f_ext == FCW'(NUM_FILTERS - 1));

  // walk phases: ST_HDR reads header; ST_COND reads condition; ST_SRCH reads tag;
  // ST_CHK compares
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_item.cmd)
            CMD_TAG:  state_next = in_item.last ? ((in_item.kind == KIND_REL) ? ST_OUT
                                                                             : ST_HDR)
                                                : ST_IDLE;
            CMD_EVAL: state_next = (in_item.kind == KIND_REL) ? ST_OUT : ST_HDR;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_HDR:  state_next = ST_COND;
      ST_COND: begin
        if (c == '0 && !h_apply) state_next = last_filter ? ST_OUT : ST_HDR;
        else if (c >= fcnt && c != '0) state_next = ST_OUT;
        else if (c == '0 && cnt_cl == '0) state_next = ST_OUT;
        else state_next = ST_SRCH;
      end
      ST_SRCH: state_next = (lo < hi) ? ST_CHK : (last_filter ? ST_OUT : ST_HDR);
      ST_CHK: begin
        if (key_hit) state_next = cond_ok ? ST_COND : (last_filter ? ST_OUT : ST_HDR);
        else state_next = ST_SRCH;
      end
      ST_OUT:  state_next = out_ready ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      case (in_item.cmd)
        CMD_COND: if (is_cond_ok) begin
          ckey_mem[cwr_idx] <= in_item.key;
          cvo_mem[cwr_idx]  <= {in_item.op, in_item.value};
        end
        CMD_HDR: if (is_hdr_ok) begin
          hdr_mem[fwr_idx] <= {in_item.cnt, in_item.zh, in_item.zl, in_item.kind};
        end
        CMD_TAG: if (32'(tag_count) < 32'(MAX_TAGS)) begin
          tkey_mem[tag_count[TW-1:0]] <= in_item.key;
          tval_mem[tag_count[TW-1:0]] <= in_item.value;
        end
        default: ;
      endcase
    end
    hdr_q  <= hdr_mem[f];
    ckey_q <= ckey_mem[crd_idx];
    cvo_q  <= cvo_mem[crd_idx];
    tkey_q <= tkey_mem[mid[TW-1:0]];
    tval_q <= tval_mem[mid[TW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid        <= '0;
      tag_count     <= '0;
      overflow_flag <= 1'b0;
      f             <= '0;
      c             <= '0;
      fcnt          <= '0;
      lo            <= '0;
      hi            <= '0;
      res_app       <= 1'b0;
      res_ovf       <= 1'b0;
      cur           <= '0;
    end else begin
      case (state)
        ST_IDLE: if (in_valid) begin
          cur     <= in_item;
          f       <= '0;
          c       <= '0;
          res_app <= 1'b0;
          case (in_item.cmd)
            CMD_HDR: if (is_hdr_ok) fvalid[fwr_idx] <= 1'b1;
            CMD_TAG: begin
              res_ovf <= ovf_now;
              if (in_item.last) begin
                hi            <= (32'(tag_count) < 32'(MAX_TAGS)) ? tag_count + NW'(1)
                                                                  : tag_count;
                tag_count     <= '0;
                overflow_flag <= 1'b0;
              end else if (32'(tag_count) < 32'(MAX_TAGS)) begin
                tag_count <= tag_count + NW'(1);
              end else begin
                overflow_flag <= 1'b1;
              end
            end
            CMD_EVAL: begin
              hi            <= '0;
              tag_count     <= '0;
              overflow_flag <= 1'b0;
              res_ovf       <= 1'b0;
            end
            default: ;
          endcase
        end
        ST_COND: begin
          if (c == '0) fcnt <= cnt_cl;
          // every condition searches the whole stored tag set
          lo <= '0;
          hi <= nstored;
          if (c == '0 && !h_apply) begin
            f <= f + FW'(1);
          end else if ((c >= fcnt && c != '0) || (c == '0 && cnt_cl == '0)) begin
            res_app <= 1'b1;
          end
        end
        ST_SRCH: begin
          if (!(lo < hi)) begin
            f <= f + FW'(1);
            c <= '0;
          end
        end
        ST_CHK: begin
          if (key_hit) begin
            if (cond_ok) c <= c + CNW'(1);
            else begin
              f <= f + FW'(1);
              c <= '0;
            end
          end else if (key_gt) hi <= mid;
          else lo <= mid + NW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) nstored <= '0;
    else if (state == ST_IDLE && in_valid && in_item.cmd == CMD_TAG && in_item.last)
      nstored <= (32'(tag_count) < 32'(MAX_TAGS)) ? tag_count + NW'(1) : tag_count;
    else if (state == ST_IDLE && in_valid && in_item.cmd == CMD_EVAL)
      nstored <= '0;
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(applicable))
    else $error("result changed while waiting");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && cur.kind == KIND_REL) |-> !applicable)
    else $error("relation gave applicable");
  assert property (@(posedge clk) disable iff (rst)
    32'(tag_count) <= 32'(MAX_TAGS))
    else $error("tag count beyond store");
endmodule

/* hdl/tag_rule_filter_matcher.sv */
// a tag or rule write is taken from the 4-entry queue by the idle engine;
// an element end walks the filters in order until one applies or the last
// is done (a relation skips the walk), then holds the result until taken
// throughput: one tag or rule write per cycle while the engine is idle
// reset: synchronous, clears filter valid bits, tag count, overflow flag, queue
module tag_rule_filter_matcher #(
  parameter int NUM_FILTERS    = 64,
  parameter int MAX_CONDITIONS = 8,
  parameter int MAX_TAGS       = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [5:0]  filter_index,
  input  logic [2:0]  cond_index,
  input  logic [1:0]  kind,
  input  logic [4:0]  zoom_low,
  input  logic [4:0]  zoom_high,
  input  logic [3:0]  cond_count,
  input  logic [4:0]  level,
  input  logic [31:0] key_id,
  input  logic [31:0] value_id,
  input  logic [1:0]  op,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        applicable,
  output logic        tag_overflow
);
  import trfm_pkg::*;

  item_t q_in, q_out;
  logic  q_valid, q_ready;

  assign q_in = '{cmd: command, fidx: filter_index, cidx: cond_index, kind: kind,
                  zl: zoom_low, zh: zoom_high, cnt: cond_count, level: level,
                  key: key_id, value: value_id, op: op, last: last};

  trfm_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(q_in),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_out)
  );

  trfm_engine #(
    .NUM_FILTERS(NUM_FILTERS), .MAX_CONDITIONS(MAX_CONDITIONS), .MAX_TAGS(MAX_TAGS)
  ) u_engine (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_out),
    .out_valid(out_valid), .out_ready(out_ready),
    .applicable(applicable), .tag_overflow(tag_overflow)
  );
endmodule

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trfm_pkg::*;

  localparam int NFILT = 64;
  localparam int NCOND = 8;
  localparam int NTAGS = 32;
  localparam int WATCHDOG_LIMIT = 100000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_EVAL;
  logic [5:0]  filter_index = '0;
  logic [2:0]  cond_index = '0;
  logic [1:0]  kind = '0;
  logic [4:0]  zoom_low = '0;
  logic [4:0]  zoom_high = '0;
  logic [3:0]  cond_count = '0;
  logic [4:0]  level = '0;
  logic [31:0] key_id = '0;
  logic [31:0] value_id = '0;
  logic [1:0]  op = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        applicable;
  logic        tag_overflow;

  tag_rule_filter_matcher u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit          flt_valid[NFILT];
  logic [1:0]  flt_kind[NFILT];
  logic [4:0]  flt_zl[NFILT];
  logic [4:0]  flt_zh[NFILT];
  logic [3:0]  flt_cnt[NFILT];
  logic [31:0] rule_key[NFILT*NCOND];
  logic [31:0] rule_val[NFILT*NCOND];
  logic [1:0]  rule_op[NFILT*NCOND];
  bit          rule_written[NFILT*NCOND];
  logic [31:0] elem_key[NTAGS];
  logic [31:0] elem_val[NTAGS];
  int          elem_tags;
  bit          elem_ovf;

  logic [1:0]  verdict_q[$];
  int          fail_count;
  int          verdicts_seen;
  int          items_sent;
  int          stall_pct;
  int          gap_pct;
  bit          hold_off;
  int          quiet_cycles;

  function automatic bit cond_holds(logic [31:0] k, logic [31:0] v, logic [1:0] o);
    int lo, hi, mid;
    lo = 0;
    hi = elem_tags;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (elem_key[mid] == k) begin
        case (o)
          OP_EXISTS: return 1'b1;
          OP_EQ:     return elem_val[mid] == v;
          OP_NE:     return elem_val[mid] != v;
          default:   return 1'b0;
        endcase
      end
      if (elem_key[mid] > k) hi = mid;
      else lo = mid + 1;
    end
    return 1'b0;
  endfunction

  function automatic bit element_matches(logic [1:0] k, logic [4:0] lv);
    int cnt;
    bit ok;
    if (k == KIND_REL) return 1'b0;
    for (int f = 0; f < NFILT; f++) begin
      if (!flt_valid[f] || flt_kind[f] != k) continue;
      if (lv < flt_zl[f] || lv > flt_zh[f]) continue;
      cnt = (flt_cnt[f] > NCOND) ? NCOND : flt_cnt[f];
      ok = 1'b1;
      for (int c = 0; c < cnt && ok; c++)
        ok = cond_holds(rule_key[f*NCOND+c], rule_val[f*NCOND+c], rule_op[f*NCOND+c]);
      if (ok) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_item();
    int idx;
    logic [1:0] v;
    case (command)
      CMD_COND: begin
        idx = filter_index * NCOND + cond_index;
        rule_key[idx] = key_id;
        rule_val[idx] = value_id;
        rule_op[idx] = op;
        rule_written[idx] = 1'b1;
      end
      CMD_HDR: begin
        flt_valid[filter_index] = 1'b1;
        flt_kind[filter_index] = kind;
        flt_zl[filter_index] = zoom_low;
        flt_zh[filter_index] = zoom_high;
        flt_cnt[filter_index] = cond_count;
      end
      CMD_TAG: begin
        if (elem_tags < NTAGS) begin
          elem_key[elem_tags] = key_id;
          elem_val[elem_tags] = value_id;
          elem_tags++;
        end else begin
          elem_ovf = 1'b1;
        end
        if (last) begin
          v = {element_matches(kind, level), elem_ovf};
          verdict_q = {verdict_q, v};
          elem_tags = 0;
          elem_ovf = 1'b0;
        end
      end
      default: begin
        elem_tags = 0;
        elem_ovf = 1'b0;
        v = {element_matches(kind, level), 1'b0};
        verdict_q = {verdict_q, v};
      end
    endcase
  endtask

  // input side: predict on the transfer
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_item();
      items_sent++;
    end
  end

  // result check
  always @(posedge clk) begin
    logic [1:0] exp_v;
    if (!rst && out_valid && out_ready) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        $error("result with nothing expected: applicable=%0d tag_overflow=%0d",
               applicable, tag_overflow);
        fail_count++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (applicable !== exp_v[1]) begin
          $error("applicable expected %0d actual %0d", exp_v[1], applicable);
          fail_count++;
        end
        if (tag_overflow !== exp_v[0]) begin
          $error("tag_overflow expected %0d actual %0d", exp_v[0], tag_overflow);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && verdict_q.size() == 0) || hold_off)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // called at a falling edge; leaves valid high so the next item can follow at once
  task automatic send_item(logic [1:0] c, logic [5:0] fi, logic [2:0] ci, logic [1:0] k,
                           logic [4:0] zl, logic [4:0] zh, logic [3:0] cnt,
                           logic [4:0] lv, logic [31:0] key, logic [31:0] val,
                           logic [1:0] o, logic lst);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    command <= c;  filter_index <= fi;  cond_index <= ci;  kind <= k;
    zoom_low <= zl;  zoom_high <= zh;  cond_count <= cnt;  level <= lv;
    key_id <= key;  value_id <= val;  op <= o;  last <= lst;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic put_cond(int f, int c, logic [31:0] key, logic [31:0] val, int o);
    send_item(CMD_COND, 6'(f), 3'(c), 2'd0, 5'd0, 5'd0, 4'd0, 5'd0, key, val, 2'(o),
              1'b0);
  endtask

  // conditions are written before the header is used, so no unwritten slot gets read
  task automatic put_filter(int f, int k, int zl, int zh, int cnt);
    send_item(CMD_HDR, 6'(f), 3'd0, 2'(k), 5'(zl), 5'(zh), 4'(cnt), 5'd0, 32'd0, 32'd0,
              2'd0, 1'b0);
  endtask

  task automatic put_tag(int k, int lv, logic [31:0] key, logic [31:0] val, bit lst);
    send_item(CMD_TAG, 6'd0, 3'd0, 2'(k), 5'(lv), 5'd0, 4'd0, 5'(lv), key, val, 2'd0,
              lst);
  endtask

  task automatic put_eval(int k, int lv);
    send_item(CMD_EVAL, 6'd0, 3'd0, 2'(k), 5'd0, 5'd0, 4'd0, 5'(lv), 32'd0, 32'd0, 2'd0,
              1'b0);
  endtask

  // small key pool so random conditions hit random tags
  function automatic logic [31:0] pool_key();
    int r;
    r = $urandom_range(9);
    if (r == 9) return 32'hFFFF_FFF0 + $urandom_range(15);
    return r * 3 + 1;
  endfunction

  function automatic logic [31:0] pool_val();
    return ($urandom_range(3) == 0) ? $urandom() : $urandom_range(2);
  endfunction

  task automatic test_directed();
    put_eval(0, 0);                                  // no filters yet
    put_tag(1, 5, 32'h1, 32'h2, 1);
    put_filter(0, 0, 0, 31, 0);                      // matches any node
    put_eval(0, 31);
    put_eval(3, 10);                                 // relation never applies
    put_cond(1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_EQ);
    put_cond(1, 1, 32'h0, 32'h0, OP_NE);
    put_cond(1, 2, 32'h10, 32'h0, OP_EXISTS);
    put_filter(1, 1, 3, 7, 3);
    put_tag(1, 3, 32'h0, 32'h5, 0);
    put_tag(1, 3, 32'h10, 32'h0, 0);
    put_tag(1, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);  // all met
    put_tag(1, 8, 32'h0, 32'h5, 1);                  // level outside range
    put_filter(2, 2, 20, 10, 0);                     // empty zoom range
    put_eval(2, 15);
    put_cond(3, 0, 32'h7, 32'h1, 3);                 // unknown op
    put_filter(3, 2, 0, 31, 15);                     // count clipped
    for (int c = 1; c < NCOND; c++) put_cond(3, c, 32'h7, 32'h1, OP_EXISTS);
    put_tag(2, 4, 32'h7, 32'h1, 1);
    put_tag(0, 0, 32'h1, 32'h1, 0);                  // pending tags dropped by eval
    put_eval(1, 5);
  endtask

  task automatic test_overflow();
    for (int t = 0; t < NTAGS + 3; t++)
      put_tag(0, $urandom_range(31), t * 2, $urandom(), t == NTAGS + 2);
    for (int t = 0; t < NTAGS; t++)
      put_tag(1, 5, t, t, t == NTAGS - 1);         // exactly full
    put_tag(1, 5, 32'h9, 32'h9, 0);
    put_tag(1, 5, 32'h3, 32'h9, 1);                // unsorted
  endtask

  task automatic random_element();
    int k;
    int lv, n, key;
    k = $urandom_range(3);
    lv = $urandom_range(31);
    if ($urandom_range(9) == 0) begin
      put_eval(k, lv);
      return;
    end
    n = ($urandom_range(19) == 0) ? $urandom_range(NTAGS + 4) + 1 : $urandom_range(6) + 1;
    key = $urandom_range(2);
    for (int t = 0; t < n; t++) begin
      if ($urandom_range(30) == 0) put_cond($urandom_range(63), $urandom_range(7),
                                            pool_key(), pool_val(), $urandom_range(3));
      put_tag(k, lv, (n > 10 || $urandom_range(15) == 0) ? $urandom() : key,
              pool_val(), t == n - 1);
      key += $urandom_range(3) + 1;
    end
  endtask

  task automatic random_filter();
    int f, cnt;
    f = $urandom_range(NFILT - 1);
    cnt = $urandom_range(15);
    for (int c = 0; c < NCOND; c++)
      if (!rule_written[f*NCOND+c] || $urandom_range(1))
        put_cond(f, c, pool_key(), pool_val(), $urandom_range(3));
    put_filter(f, $urandom_range(3), $urandom_range(31), $urandom_range(31), cnt);
  endtask

  task automatic test_random(int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(7) == 0) random_filter();
      else random_element();
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) put_eval($urandom_range(2), $urandom_range(31));
        release_input();
      end
    join
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    stall_pct = 0;  gap_pct = 0;
    test_directed();
    test_overflow();
    release_input();
    wait_drained();
    test_backpressure();
    test_random(300);
    stall_pct = 0;  gap_pct = 55;
    test_random(300);
    stall_pct = 55; gap_pct = 0;
    test_random(300);
    stall_pct = 11; gap_pct = 11;
    test_random(300);
    release_input();
    wait_drained();
    $display("covered %0d transfers in, %0d results checked", items_sent, verdicts_seen);
    $display("rule writes, tag streams, overflow, relation and empty evals under idling");
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
